// ===== src/qph_pkg.sv =====
// shared constants for the quadratic probe hash table
// no dependencies; imported by qph_rem and quadratic_probe_hash_table_top
`timescale 1ns / 1ps

package qph_pkg;

	localparam int TABLE_DEPTH = 16384;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = 15;
	localparam int CNT_W       = 15;
	localparam int KEY_W       = 32;

	// remainder unit retires this many dividend bits per cycle
	localparam int REM_BITS_PER_CYC = 4;
	localparam int REM_STEPS        = KEY_W / REM_BITS_PER_CYC;
	localparam int REM_STEP_W       = $clog2(REM_STEPS);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16381);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

endpackage

// ===== src/qph_rem.sv =====
// iterative remainder unit: dividend mod divisor, REM_BITS_PER_CYC dividend bits per cycle
// depends on qph_pkg
`timescale 1ns / 1ps

module qph_rem
	import qph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [SIZE_W-1:0] rem
);

	logic                  busy_q;
	logic [REM_STEP_W-1:0] step_q;
	logic [KEY_W-1:0]      shift_q;
	logic [SIZE_W-1:0]     div_q;
	logic [SIZE_W-1:0]     rem_q;
	logic [SIZE_W-1:0]     rem_next;

	// restoring steps over the top dividend bits
	always_comb begin
		logic [SIZE_W:0] trial;
		rem_next = rem_q;
		for (int b = 0; b < REM_BITS_PER_CYC; b++) begin
			trial = {rem_next, shift_q[KEY_W-1-b]};
			if (trial >= {1'b0, div_q}) begin
				trial = trial - {1'b0, div_q};
			end
			rem_next = trial[SIZE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && (step_q == REM_STEP_W'(REM_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == REM_STEP_W'(REM_STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			div_q   <= divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << REM_BITS_PER_CYC;
			rem_q   <= rem_next;
		end
	end

	assign rem = rem_q;

endmodule

// ===== src/quadratic_probe_hash_table_top.sv =====
// quadratic probe hash table: fsm, slot memory, probe address walk
// depends on qph_pkg and qph_rem
`timescale 1ns / 1ps

// Open-addressing hash table with quadratic probing: probe i of a key looks at
// slot (key + i*i) mod S, S being table_size clamped to 1..16384 (write a prime).
// After reset the block clears the slot memory one entry a cycle and takes no
// request until that is done; table_size writes are taken at any time but should
// only be made while idle. A request is taken in an idle cycle; the key mod S is
// then worked out at 4 bits a cycle, the first slot is read, and the probes run
// with one read of the single slot memory each cycle before the result is
// registered onto the outputs, held back while an earlier result waits on
// out_ready. No new request is taken until the last one is through. Inserts
// report insert_failed with slot_index 0 when no empty slot is found; searches
// report probe_count up to S+1.
module quadratic_probe_hash_table_top
	import qph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] table_size,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [KEY_W-1:0]  key,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              insert_failed,
	output logic [ADDR_W-1:0] slot_index,
	output logic [CNT_W-1:0]  probe_count
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] s_eff;
	logic [SIZE_W-1:0] s_op_q;
	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [ADDR_W-1:0] p_q;
	logic [ADDR_W-1:0] inc_q;
	logic [CNT_W-1:0]  i_q;

	logic              res_failed_q;
	logic [ADDR_W-1:0] res_slot_q;
	logic [CNT_W-1:0]  res_count_q;
	logic              out_valid_q;
	logic              out_failed_q;
	logic [ADDR_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_count_q;

	logic              rem_start;
	logic              rem_done;
	logic [SIZE_W-1:0] rem_val;

	logic [KEY_W-1:0]  mem [TABLE_DEPTH];
	logic [KEY_W-1:0]  rdata_s1;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [KEY_W-1:0]  wr_data;

	logic [SIZE_W-1:0] p_sum;
	logic [SIZE_W-1:0] inc_sum;
	logic [ADDR_W-1:0] p_next;
	logic [ADDR_W-1:0] inc_next;
	logic [CNT_W-1:0]  i_inc;
	logic              last_probe;
	logic              hit_empty;
	logic              hit_key;
	logic              load_out;
	logic              in_acc;

	// clamp the written size into the usable range
	always_comb begin
		s_eff = size_q;
		if (size_q == '0) begin
			s_eff = SIZE_W'(1);
		end else if (size_q > SIZE_W'(TABLE_DEPTH)) begin
			s_eff = SIZE_W'(TABLE_DEPTH);
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign rem_start = in_acc;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	qph_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (key),
		.divisor  (s_eff),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// next probe: p += (2i+1) mod S, then step the increment (2i+1) by two, mod S
	always_comb begin
		p_sum   = {1'b0, p_q} + {1'b0, inc_q};
		inc_sum = {1'b0, inc_q} + SIZE_W'(2);
		if (p_sum >= s_op_q) begin
			p_sum = p_sum - s_op_q;
		end
		if (inc_sum >= s_op_q) begin
			inc_sum = inc_sum - s_op_q;
		end
		p_next = p_sum[ADDR_W-1:0];
		if (s_op_q == SIZE_W'(1)) begin
			inc_next = '0;
		end else begin
			inc_next = inc_sum[ADDR_W-1:0];
		end
	end

	assign i_inc      = i_q + 1'b1;
	assign last_probe = (i_inc == s_op_q);
	assign hit_empty  = (rdata_s1 == '0);
	assign hit_key    = (rdata_s1 == key_q);

	assign rd_addr = (state_q == ST_DIV) ? rem_val[ADDR_W-1:0] : p_next;

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = p_q;
		wr_data = key_q;
		if (state_q == ST_CLEAR) begin
			mem_we  = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (state_q == ST_PROBE && kind_q == KIND_INSERT && hit_empty) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= table_size;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (kind_q == KIND_INSERT) begin
						if (hit_empty || last_probe) begin
							state_q <= ST_DONE;
						end
					end else if (hit_empty || hit_key || last_probe) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and probe walk registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= kind;
			key_q  <= key;
			s_op_q <= s_eff;
		end
		if (state_q == ST_DIV && rem_done) begin
			p_q   <= rem_val[ADDR_W-1:0];
			inc_q <= (s_op_q == SIZE_W'(1)) ? '0 : ADDR_W'(1);
			i_q   <= '0;
		end else if (state_q == ST_PROBE) begin
			p_q   <= p_next;
			inc_q <= inc_next;
			i_q   <= i_inc;
			res_failed_q <= (kind_q == KIND_INSERT) && !hit_empty;
			res_slot_q   <= (kind_q == KIND_INSERT && hit_empty) ? p_q : '0;
			if (kind_q == KIND_INSERT) begin
				res_count_q <= '0;
			end else if (hit_empty || hit_key) begin
				res_count_q <= i_inc;
			end else begin
				res_count_q <= i_inc + 1'b1;
			end
		end
		if (load_out) begin
			out_failed_q <= res_failed_q;
			out_slot_q   <= res_slot_q;
			out_count_q  <= res_count_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign insert_failed = out_failed_q;
	assign slot_index    = out_slot_q;
	assign probe_count   = out_count_q;

	// probe walk stays inside the table in use
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> ({1'b0, p_q} < s_op_q))
		else $error("probe slot beyond table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> ({1'b0, inc_q} < s_op_q) && (i_q < s_op_q))
		else $error("probe increment or count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_PROBE))
		else $error("slot memory written outside clear or probe");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_DIV) && !in_ready)
		else $error("request not handed to remainder unit");

endmodule
